@@ design/iol_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed ordered list package
// Shared constants, command and status codes, and the command and result
// words passed between the list modules.
// ----------------------------------------------------------------------------
package iol_pkg;

  localparam int Capacity    = 16;
  localparam int ValueWidth  = 32;

  localparam int CmdWidth      = 4;
  localparam int IndexWidth    = 5;
  localparam int OutWidth      = 32;
  localparam int CountOutWidth = 5;
  localparam int StatusWidth   = 2;

  localparam int CountWidth = $clog2(Capacity + 1);
  localparam int PosWidth   = $clog2(Capacity);
  localparam int CmpWidth   = (CountWidth > IndexWidth) ? CountWidth : IndexWidth;

  typedef logic signed [ValueWidth-1:0] value_t;

  typedef enum logic [CmdWidth-1:0] {
    CmdInsertAt  = 4'd0,
    CmdRemoveAt  = 4'd1,
    CmdReadAt    = 4'd2,
    CmdWriteAt   = 4'd3,
    CmdPushFront = 4'd4,
    CmdPopFront  = 4'd5,
    CmdPushBack  = 4'd6,
    CmdPopBack   = 4'd7,
    CmdClear     = 4'd8
  } cmd_e;

  typedef enum logic [StatusWidth-1:0] {
    StOk    = 2'd0,
    StRange = 2'd1,
    StFull  = 2'd2,
    StEmpty = 2'd3
  } status_e;

  typedef struct packed {
    logic [CmdWidth-1:0]   cmd;
    logic [IndexWidth-1:0] index;
    logic [OutWidth-1:0]   value;
  } iol_cmd_t;

  typedef struct packed {
    status_e                  status;
    logic [OutWidth-1:0]      read_value;
    logic [CountOutWidth-1:0] count;
    logic [OutWidth-1:0]      front_value;
    logic [OutWidth-1:0]      back_value;
  } iol_res_t;

  // Sign-extends or truncates a stored value to the reported width.
  function automatic logic [OutWidth-1:0] widen(value_t v);
    return OutWidth'(v);
  endfunction

endpackage
`default_nettype wire

@@ design/iol_if.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed ordered list channels
// Valid/ready channels for command words and result words.
// ----------------------------------------------------------------------------
interface iol_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [4:0]  index;
  logic [31:0] value;

  modport source (output valid, output cmd, output index, output value, input ready);
  modport sink   (input valid, input cmd, input index, input value, output ready);
endinterface

interface iol_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] read_value;
  logic [4:0]  count;
  logic [31:0] front_value;
  logic [31:0] back_value;

  modport source (output valid, output status, output read_value, output count,
                  output front_value, output back_value, input ready);
  modport sink   (input valid, input status, input read_value, input count,
                  input front_value, input back_value, output ready);
endinterface
`default_nettype wire

@@ design/iol_list.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed ordered list storage
// Row of entry cells with a per-position shift mux, the entry count, and the
// checks and reads that form one result word per executed command.
// ----------------------------------------------------------------------------
module iol_list import iol_pkg::*; (
  input  wire logic     clk_i,
  input  wire logic     rst_ni,
  input  wire logic     exec_i,
  input  wire iol_cmd_t cmd_i,
  output iol_res_t      res_o
);

  value_t                entries_q [Capacity];
  value_t                entries_d [Capacity];
  logic [CountWidth-1:0] count_q, count_d;

  logic [CmpWidth-1:0] idx_x, cnt_x;
  logic                full, empty, idx_le, idx_lt;
  logic                do_open, do_close, do_write, do_read, do_clear;
  logic [PosWidth-1:0] pos, back_pos;
  value_t              new_val;
  status_e             status;

  assign idx_x   = CmpWidth'(cmd_i.index);
  assign cnt_x   = CmpWidth'(count_q);
  assign full    = (count_q == CountWidth'(Capacity));
  assign empty   = (count_q == '0);
  assign idx_le  = (idx_x <= cnt_x);
  assign idx_lt  = (idx_x < cnt_x);
  assign new_val = ValueWidth'(signed'(cmd_i.value));

  // Decode: every change to the row is an open, a close or a write at pos.
  always_comb begin
    status   = StOk;
    do_open  = 1'b0;
    do_close = 1'b0;
    do_write = 1'b0;
    do_read  = 1'b0;
    do_clear = 1'b0;
    pos      = PosWidth'(cmd_i.index);
    case (cmd_e'(cmd_i.cmd))
      CmdInsertAt: begin
        if (!idx_le) status = StRange;
        else if (full) status = StFull;
        else do_open = 1'b1;
      end
      CmdRemoveAt: begin
        if (!idx_lt) status = StRange;
        else begin
          do_close = 1'b1;
          do_read  = 1'b1;
        end
      end
      CmdReadAt: begin
        if (!idx_lt) status = StRange;
        else do_read = 1'b1;
      end
      CmdWriteAt: begin
        if (!idx_lt) status = StRange;
        else do_write = 1'b1;
      end
      CmdPushFront: begin
        pos = '0;
        if (full) status = StFull;
        else do_open = 1'b1;
      end
      CmdPopFront: begin
        pos = '0;
        if (empty) status = StEmpty;
        else begin
          do_close = 1'b1;
          do_read  = 1'b1;
        end
      end
      CmdPushBack: begin
        pos = PosWidth'(count_q);
        if (full) status = StFull;
        else do_open = 1'b1;
      end
      CmdPopBack: begin
        pos = PosWidth'(count_q - CountWidth'(1));
        if (empty) status = StEmpty;
        else begin
          do_close = 1'b1;
          do_read  = 1'b1;
        end
      end
      CmdClear: do_clear = 1'b1;
      default: ;
    endcase
  end

  // Each cell takes its lower neighbor, its upper neighbor, the new value or
  // holds. Cells at or above the count are don't-care.
  always_comb begin
    for (int i = 0; i < Capacity; i++) begin
      entries_d[i] = entries_q[i];
      if (do_open) begin
        if (PosWidth'(i) == pos) entries_d[i] = new_val;
        else if (i > 0 && PosWidth'(i) > pos) entries_d[i] = entries_q[(i > 0) ? i - 1 : 0];
      end else if (do_close) begin
        if (i < Capacity - 1 && PosWidth'(i) >= pos)
          entries_d[i] = entries_q[(i < Capacity - 1) ? i + 1 : i];
      end else if (do_write && PosWidth'(i) == pos) begin
        entries_d[i] = new_val;
      end
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_clear) count_d = '0;
    else if (do_open) count_d = count_q + CountWidth'(1);
    else if (do_close) count_d = count_q - CountWidth'(1);
  end

  assign back_pos = PosWidth'(count_d - CountWidth'(1));

  always_comb begin
    res_o.status      = status;
    res_o.read_value  = do_read ? widen(entries_q[pos]) : '0;
    res_o.count       = CountOutWidth'(count_d);
    res_o.front_value = (count_d == '0) ? '0 : widen(entries_d[0]);
    res_o.back_value  = (count_d == '0) ? '0 : widen(entries_d[back_pos]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (exec_i) begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (exec_i) begin
      entries_q <= entries_d;
    end
  end

endmodule
`default_nettype wire

@@ design/indexed_ordered_list_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed ordered list unit
// Ordered list of signed values with indexed insert, remove, read and write,
// push and pop at both ends, and clear.
// ----------------------------------------------------------------------------
// Usage:
// Command words arrive on in_i (cmd, index, value) and each one produces
// exactly one result word on out_o (status, read_value, count, front_value,
// back_value), in order. A command that fails its checks (index out of
// range, list full, list empty) reports that status and leaves the list as
// it was.
// A word accepted on in_i is latched in the input register, executed against
// the entry row once the output register is free or being drained, and its
// result is shown from the output register.
// Throughput is one word per cycle while out_o.ready stays high. The entry
// row updates every cell in parallel through a per-position shift mux, so
// each command finishes as one whole-row update and the next one sees the updated list.
// When the receiver holds out_o.ready low, the result stays in the output
// register and one more word waits in the input register; in_i.ready falls
// only when both are full.
// Reset empties the list and drops both pipeline registers. Entry contents
// are not cleared; entries are only read at positions below the count.
// ----------------------------------------------------------------------------
module indexed_ordered_list_unit import iol_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iol_in_if.sink    in_i,
  iol_out_if.source out_o
);

  // Input register stage.
  logic     in_vld_q;
  iol_cmd_t in_cmd_q;

  // Output register stage.
  logic     out_vld_q;
  iol_res_t out_res_q;

  iol_res_t res;
  logic     exec;
  logic     in_take;

  // A latched command executes when the output register is free or is being
  // drained in this same cycle.
  assign exec    = in_vld_q && (!out_vld_q || out_o.ready);
  assign in_i.ready = !in_vld_q || exec;
  assign in_take = in_i.valid && in_i.ready;

  iol_list u_list (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .exec_i (exec),
    .cmd_i  (in_cmd_q),
    .res_o  (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      if (in_take) in_vld_q <= 1'b1;
      else if (exec) in_vld_q <= 1'b0;
      if (exec) out_vld_q <= 1'b1;
      else if (out_o.ready) out_vld_q <= 1'b0;
    end
  end

  // Payload registers carry no reset; the valid flags qualify them.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      in_cmd_q.cmd   <= in_i.cmd;
      in_cmd_q.index <= in_i.index;
      in_cmd_q.value <= in_i.value;
    end
    if (exec) begin
      out_res_q <= res;
    end
  end

  assign out_o.valid       = out_vld_q;
  assign out_o.status      = out_res_q.status;
  assign out_o.read_value  = out_res_q.read_value;
  assign out_o.count       = out_res_q.count;
  assign out_o.front_value = out_res_q.front_value;
  assign out_o.back_value  = out_res_q.back_value;

  // A full-list refusal can only happen at capacity.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && res.status == StFull |-> res.count == CountOutWidth'(Capacity))
    else $error("full status reported below capacity");

  // An empty-list refusal can only happen with no entries.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && res.status == StEmpty |-> res.count == '0)
    else $error("empty status reported with entries present");

  // An empty list reports zero at both ends.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    exec && res.count == '0 |-> res.front_value == '0 && res.back_value == '0)
    else $error("nonzero front or back on an empty list");

  // The input side stalls only while a word waits in the input register and a result waits in the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_i.ready |-> in_vld_q && out_vld_q)
    else $error("input stalled with a free pipeline stage");

endmodule
`default_nettype wire

@@ test/tb_indexed_ordered_list_unit.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// Indexed ordered list unit testbench
// Sends command words to the list unit through its valid/ready channels and
// checks every result word against a scoreboard. The scoreboard keeps its own
// copy of the list. Stimulus is a directed opening over the empty and full
// corner cases, then random command mixes that push the list toward full or
// toward empty. Random idle gaps on the command side and random stalls on the
// result side are on in the opening, set at random per segment, and off in the final stretch.
// ----------------------------------------------------------------------------
module tb_indexed_ordered_list_unit;
  import iol_pkg::*;

  // Command codes that the unit ignores.
  localparam logic [CmdWidth-1:0] CmdUnusedFirst = 4'd9;
  localparam logic [CmdWidth-1:0] CmdUnusedLast  = 4'd15;

  localparam int SegmentWords   = 50;
  localparam int RandomSegments = 19;
  localparam int QuietSegments  = 3;
  localparam int DrainCycles    = 8;
  localparam int CycleLimit     = 500000;
  localparam int PrintLimit     = 40;

  // --------------------------------------------------------------------------
  // Scoreboard: mirrors the list, predicts one result per accepted command
  // and compares the results in order.
  // --------------------------------------------------------------------------
  class list_scoreboard;
    value_t      entries [Capacity];
    int unsigned entry_count;
    iol_res_t    expected_q [$];
    int unsigned mismatches;
    int unsigned words_noted;
    int unsigned words_checked;
    int unsigned status_tally [4];
    int unsigned full_hits;
    int unsigned empty_hits;

    function new();
      entry_count   = 0;
      mismatches    = 0;
      words_noted   = 0;
      words_checked = 0;
      full_hits     = 0;
      empty_hits    = 0;
      foreach (status_tally[s]) status_tally[s] = 0;
    endfunction

    // Moves entries at pos and above up by one and grows the list.
    function void open_slot(int unsigned pos);
      for (int unsigned i = entry_count; i > pos; i--) entries[i] = entries[i-1];
      entry_count++;
    endfunction

    // Takes out the entry at pos and moves the later ones down.
    function value_t close_slot(int unsigned pos);
      value_t taken;
      taken = entries[pos];
      for (int unsigned i = pos; i + 1 < entry_count; i++) entries[i] = entries[i+1];
      entry_count--;
      return taken;
    endfunction

    function void note_command(logic [CmdWidth-1:0] cmd, logic [IndexWidth-1:0] index,
                               logic [OutWidth-1:0] value);
      int unsigned pos;
      value_t      stored;
      value_t      taken;
      status_e     st;
      iol_res_t    want;
      pos    = 32'(index);
      stored = value_t'(value);
      taken  = '0;
      st     = StOk;
      case (cmd)
        CmdInsertAt: begin
          // The range check wins over the full check.
          if (pos > entry_count) st = StRange;
          else if (entry_count >= Capacity) st = StFull;
          else begin
            open_slot(pos);
            entries[pos] = stored;
          end
        end
        CmdRemoveAt: begin
          if (pos >= entry_count) st = StRange;
          else taken = close_slot(pos);
        end
        CmdReadAt: begin
          if (pos >= entry_count) st = StRange;
          else taken = entries[pos];
        end
        CmdWriteAt: begin
          if (pos >= entry_count) st = StRange;
          else entries[pos] = stored;
        end
        CmdPushFront: begin
          if (entry_count >= Capacity) st = StFull;
          else begin
            open_slot(0);
            entries[0] = stored;
          end
        end
        CmdPopFront: begin
          if (entry_count == 0) st = StEmpty;
          else taken = close_slot(0);
        end
        CmdPushBack: begin
          if (entry_count >= Capacity) st = StFull;
          else begin
            entries[entry_count] = stored;
            entry_count++;
          end
        end
        CmdPopBack: begin
          if (entry_count == 0) st = StEmpty;
          else begin
            entry_count--;
            taken = entries[entry_count];
          end
        end
        CmdClear: entry_count = 0;
        default: ;
      endcase
      want.status      = st;
      want.read_value  = OutWidth'(taken);
      want.count       = CountOutWidth'(entry_count);
      want.front_value = (entry_count == 0) ? '0 : OutWidth'(entries[0]);
      want.back_value  = (entry_count == 0) ? '0 : OutWidth'(entries[entry_count-1]);
      if (entry_count == Capacity) full_hits++;
      if (entry_count == 0) empty_hits++;
      expected_q = {expected_q, want};
      words_noted++;
    endfunction

    task report_mismatch(string msg);
      mismatches++;
      if (mismatches <= PrintLimit) $display("mismatch: %s", msg);
    endtask

    task check_result(iol_res_t got);
      iol_res_t want;
      if (expected_q.size() == 0) begin
        report_mismatch($sformatf("result word with nothing outstanding (status %0d, count %0d)",
                                  got.status, got.count));
        return;
      end
      want = expected_q[0];
      expected_q.delete(0);
      words_checked++;
      status_tally[int'(got.status)]++;
      if (got.status != want.status)
        report_mismatch($sformatf("word %0d status %0d, predicted %0d",
                                  words_checked, got.status, want.status));
      if (got.read_value != want.read_value)
        report_mismatch($sformatf("word %0d read_value %h, predicted %h",
                                  words_checked, got.read_value, want.read_value));
      if (got.count != want.count)
        report_mismatch($sformatf("word %0d count %0d, predicted %0d",
                                  words_checked, got.count, want.count));
      if (got.front_value != want.front_value)
        report_mismatch($sformatf("word %0d front_value %h, predicted %h",
                                  words_checked, got.front_value, want.front_value));
      if (got.back_value != want.back_value)
        report_mismatch($sformatf("word %0d back_value %h, predicted %h",
                                  words_checked, got.back_value, want.back_value));
    endtask
  endclass

  logic        clk = 1'b0;
  logic        rst_n;
  int unsigned cycle_count = 0;
  bit          in_gaps_on;
  bit          out_stalls_on;

  list_scoreboard sb = new();

  iol_in_if  cmd_ch ();
  iol_out_if res_ch ();

  indexed_ordered_list_unit uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .in_i   (cmd_ch),
    .out_o  (res_ch)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CycleLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  // Accepted command words feed the predictor.
  always @(posedge clk) begin
    if (rst_n && cmd_ch.valid && cmd_ch.ready)
      sb.note_command(cmd_ch.cmd, cmd_ch.index, cmd_ch.value);
  end

  // Accepted result words are checked in order.
  always @(posedge clk) begin
    iol_res_t got;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      got.status      = status_e'(res_ch.status);
      got.read_value  = res_ch.read_value;
      got.count       = res_ch.count;
      got.front_value = res_ch.front_value;
      got.back_value  = res_ch.back_value;
      sb.check_result(got);
    end
  end

  // Result side: ready is mostly high, dropped for random bursts while
  // stalls are enabled.
  initial begin
    res_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (out_stalls_on && $urandom_range(0, 5) == 0) begin
        res_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 14)) @(posedge clk);
      end
      res_ch.ready <= 1'b1;
    end
  end

  // Presents one command word and returns at the edge that accepts it.
  // Always called right at a rising edge.
  task automatic send_word(input logic [CmdWidth-1:0] c, input logic [IndexWidth-1:0] idx,
                           input logic [OutWidth-1:0] v);
    if (in_gaps_on && $urandom_range(0, 3) == 0) begin
      cmd_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.cmd   <= c;
    cmd_ch.index <= idx;
    cmd_ch.value <= v;
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
  endtask

  // Random command word. grow_pct steers the mix toward growing or shrinking
  // the list; the index mostly falls near the current fill so that most
  // indexed commands succeed.
  task automatic make_word(input int grow_pct, output logic [CmdWidth-1:0] c,
                           output logic [IndexWidth-1:0] idx, output logic [OutWidth-1:0] v);
    int          roll;
    int unsigned fill;
    fill = sb.entry_count;
    roll = $urandom_range(0, 99);
    if (roll < 3) c = CmdWidth'($urandom_range(CmdUnusedFirst, CmdUnusedLast));
    else if (roll < 4) c = CmdClear;
    else if (roll < 13) c = CmdReadAt;
    else if (roll < 21) c = CmdWriteAt;
    else if ($urandom_range(0, 99) < grow_pct) begin
      case ($urandom_range(0, 2))
        0:       c = CmdInsertAt;
        1:       c = CmdPushFront;
        default: c = CmdPushBack;
      endcase
    end else begin
      case ($urandom_range(0, 2))
        0:       c = CmdRemoveAt;
        1:       c = CmdPopFront;
        default: c = CmdPopBack;
      endcase
    end
    if ($urandom_range(0, 3) == 0) idx = IndexWidth'($urandom);
    else idx = IndexWidth'($urandom_range(0, fill));
    case ($urandom_range(0, 7))
      0:       v = 32'h7FFF_FFFF;
      1:       v = 32'h8000_0000;
      2:       v = '0;
      3:       v = '1;
      default: v = $urandom;
    endcase
  endtask

  initial begin
    logic [CmdWidth-1:0]   c;
    logic [IndexWidth-1:0] idx;
    logic [OutWidth-1:0]   v;
    int                    grow_pct;
    cmd_ch.valid  <= 1'b0;
    cmd_ch.cmd    <= CmdClear;
    cmd_ch.index  <= '0;
    cmd_ch.value  <= '0;
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    rst_n = 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Empty list: every failing check, clear and an ignored code.
    send_word(CmdPopFront, 5'd0, '0);
    send_word(CmdPopBack, 5'd0, '0);
    send_word(CmdRemoveAt, 5'd0, '0);
    send_word(CmdReadAt, 5'd0, '0);
    send_word(CmdWriteAt, 5'd0, 32'h0000_0005);
    send_word(CmdInsertAt, 5'd1, '0);
    send_word(CmdClear, 5'd0, '0);
    send_word(CmdUnusedLast, 5'd31, '1);

    // A few entries built from the extremes of the value field.
    send_word(CmdInsertAt, 5'd0, 32'h7FFF_FFFF);
    send_word(CmdPushFront, 5'd0, 32'h8000_0000);
    send_word(CmdPushBack, 5'd0, 32'hFFFF_FFFF);
    send_word(CmdInsertAt, 5'd3, '0);
    send_word(CmdReadAt, 5'd1, '0);
    send_word(CmdWriteAt, 5'd3, 32'h1234_5678);
    send_word(CmdRemoveAt, 5'd1, '0);
    send_word(CmdPopFront, 5'd0, '0);
    send_word(CmdInsertAt, 5'd31, '0);

    // Two entries are left; fill the list to capacity.
    for (int k = 0; k < Capacity - 2; k++) begin
      case (k % 3)
        0:       send_word(CmdPushFront, 5'd0, $urandom);
        1:       send_word(CmdInsertAt, IndexWidth'(k / 2), $urandom);
        default: send_word(CmdPushBack, 5'd0, $urandom);
      endcase
    end

    // Full list: the range check comes before the full check on insert.
    send_word(CmdInsertAt, 5'd17, '0);
    send_word(CmdInsertAt, 5'd16, '0);
    send_word(CmdPushFront, 5'd0, '0);
    send_word(CmdPushBack, 5'd0, '0);
    send_word(CmdUnusedFirst, 5'd16, 32'h8000_0000);
    send_word(CmdRemoveAt, 5'd15, '0);
    send_word(CmdPopBack, 5'd0, '0);
    send_word(CmdClear, 5'd0, '0);
    send_word(CmdPopFront, 5'd0, '0);

    // Random segments, each with its own growth bias and idling; the last
    // ones run back to back with no gaps or stalls.
    for (int seg = 0; seg < RandomSegments; seg++) begin
      case ($urandom_range(0, 3))
        0:       grow_pct = 15;
        1:       grow_pct = 50;
        2:       grow_pct = 85;
        default: grow_pct = 97;
      endcase
      if (seg >= RandomSegments - QuietSegments) begin
        in_gaps_on    = 1'b0;
        out_stalls_on = 1'b0;
      end else begin
        in_gaps_on    = ($urandom_range(0, 2) != 0);
        out_stalls_on = ($urandom_range(0, 2) != 0);
      end
      repeat (SegmentWords) begin
        make_word(grow_pct, c, idx, v);
        send_word(c, idx, v);
      end
    end
    cmd_ch.valid <= 1'b0;

    while (sb.expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("summary: %0d commands sent, %0d results checked, %0d mismatches",
             sb.words_noted, sb.words_checked, sb.mismatches);
    $display("summary: status ok/range/full/empty %0d/%0d/%0d/%0d, full %0d, empty %0d times",
             sb.status_tally[StOk], sb.status_tally[StRange], sb.status_tally[StFull],
             sb.status_tally[StEmpty], sb.full_hits, sb.empty_hits);
    if (sb.mismatches == 0 && sb.expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
